@@ rtl/core/kdt_pkg.sv @@
// Shared types and codes for the keepalive deadline table.
package kdt_pkg;

    localparam int ENTRIES_DEF = 16;

    localparam logic [2:0] OP_CONNECT    = 3'd0;
    localparam logic [2:0] OP_ACCEPT     = 3'd1;
    localparam logic [2:0] OP_RECV       = 3'd2;
    localparam logic [2:0] OP_DISCONNECT = 3'd3;
    localparam logic [2:0] OP_CHECK      = 3'd4;

    localparam logic [2:0] K_OK       = 3'd0;
    localparam logic [2:0] K_FULL     = 3'd1;
    localparam logic [2:0] K_NOTFOUND = 3'd2;
    localparam logic [2:0] K_SEND     = 3'd3;
    localparam logic [2:0] K_TIMEOUT  = 3'd4;
    localparam logic [2:0] K_DONE     = 3'd5;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] conn_id;
        logic [15:0] send_interval;
        logic [15:0] recv_timeout;
        logic [31:0] now_time;
    } req_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] peer_id;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [31:0] id;
        logic [15:0] interval;
        logic [15:0] timeout;
        logic [31:0] next_send;
        logic [31:0] deadline;
    } entry_t;

    typedef enum logic [1:0] {
        SEL_HOLD,
        SEL_NEXT,
        SEL_LOAD
    } cell_sel_t;

    typedef struct packed {
        cell_sel_t sel;
        logic      rm_en;
    } cell_ctl_t;

endpackage

@@ rtl/core/keepalive_deadline_table_unit.sv @@
// Top level of the keepalive deadline table: control sequencer and a chain of entry cells.
//
// A request is taken when start is high and busy is low. Results appear on res for one
// cycle with res_valid high and cannot be held off; the final result of a request has
// res.last set. Connect and accept finish in the accepting cycle (busy stays low, the
// result is registered for the next cycle); unused opcodes give no result. Receive-alive
// and disconnect scan the live cells one per cycle to find the earliest inserted match.
// Check walks the chain one cell per cycle, rotating a cell to the tail or dropping it
// once timed out (a cell both due and timed out also takes S_CHK_RM), then emits done.
// Cells are kept in alive order; cell 0 is the head, cell count-1 the tail.
module keepalive_deadline_table_unit
    import kdt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t req,
    output logic busy,
    output logic res_valid,
    output res_t res
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RW = IW;
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_APPLY,
        S_CHK_EVAL,
        S_CHK_RM,
        S_CHK_DONE
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] steps_reg, steps_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          found_reg, found_next;
    logic [IW-1:0] best_pos_reg, best_pos_next;
    logic [RW-1:0] best_rank_reg, best_rank_next;
    entry_t        best_reg, best_next;
    req_t          req_reg, req_next;
    logic          res_valid_reg, res_valid_next;
    res_t          res_reg, res_next;

    entry_t        cell_entry [ENTRIES];
    logic [RW-1:0] cell_rank  [ENTRIES];

    // chain control, shared by all cells
    logic [CW-1:0] shift_lo, shift_hi, load_pos;
    logic          load_en, rm_en;
    entry_t        load_data;
    logic [RW-1:0] load_rank, rm_rank;

    entry_t        scan_e, head;
    logic          due, expired;

    assign scan_e  = cell_entry[idx_reg];
    assign head    = cell_entry[0];
    assign due     = (head.next_send != 32'd0) && (req_reg.now_time >= head.next_send);
    assign expired = (head.deadline != 32'd0) && (req_reg.now_time > head.deadline);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        steps_next     = steps_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        best_pos_next  = best_pos_reg;
        best_rank_next = best_rank_reg;
        best_next      = best_reg;
        req_next       = req_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        shift_lo       = '0;
        shift_hi       = '0;
        load_en        = 1'b0;
        load_pos       = count_reg;
        load_data      = head;
        load_rank      = cell_rank[0];
        rm_en          = 1'b0;
        rm_rank        = cell_rank[0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = req;
                    if (req.opcode == OP_CONNECT || req.opcode == OP_ACCEPT)
                    begin
                        res_valid_next = 1'b1;
                        if (count_reg == CW'(ENTRIES))
                            res_next = '{kind: K_FULL, peer_id: 32'd0, last: 1'b1};
                        else
                        begin
                            load_en   = 1'b1;
                            load_pos  = count_reg;
                            load_rank = RW'(count_reg);
                            load_data.id       = req.conn_id;
                            load_data.timeout  = req.recv_timeout;
                            load_data.deadline = req.now_time + 32'(req.recv_timeout);
                            if (req.opcode == OP_CONNECT)
                            begin
                                load_data.interval  = req.send_interval;
                                load_data.next_send = req.now_time
                                                      + 32'(req.send_interval);
                            end
                            else
                            begin
                                load_data.interval  = 16'd0;
                                load_data.next_send = 32'd0;
                            end
                            count_next = count_reg + 1'b1;
                            res_next = '{kind: K_OK, peer_id: req.conn_id, last: 1'b1};
                        end
                    end
                    else if (req.opcode == OP_RECV || req.opcode == OP_DISCONNECT)
                    begin
                        if (count_reg == '0)
                        begin
                            res_valid_next = 1'b1;
                            res_next = '{kind: K_NOTFOUND, peer_id: req.conn_id,
                                         last: 1'b1};
                        end
                        else
                        begin
                            idx_next   = '0;
                            found_next = 1'b0;
                            state_next = S_FIND;
                        end
                    end
                    else if (req.opcode == OP_CHECK)
                    begin
                        if (count_reg == '0)
                        begin
                            res_valid_next = 1'b1;
                            res_next = '{kind: K_DONE, peer_id: 32'd0, last: 1'b1};
                        end
                        else
                        begin
                            steps_next = count_reg;
                            state_next = S_CHK_EVAL;
                        end
                    end
                end
            end

            S_FIND:
            begin
                // earliest inserted match wins
                if (scan_e.id == req_reg.conn_id &&
                    (!found_reg || cell_rank[idx_reg] < best_rank_reg))
                begin
                    found_next     = 1'b1;
                    best_pos_next  = idx_reg;
                    best_rank_next = cell_rank[idx_reg];
                    best_next      = scan_e;
                end
                if (CW'(idx_reg) + 1'b1 == count_reg)
                    state_next = S_APPLY;
                else
                    idx_next = idx_reg + 1'b1;
            end

            S_APPLY:
            begin
                state_next     = S_IDLE;
                res_valid_next = 1'b1;
                if (!found_reg)
                    res_next = '{kind: K_NOTFOUND, peer_id: req_reg.conn_id, last: 1'b1};
                else
                begin
                    res_next = '{kind: K_OK, peer_id: req_reg.conn_id, last: 1'b1};
                    shift_lo = CW'(best_pos_reg);
                    if (req_reg.opcode == OP_RECV)
                    begin
                        // renew and move to the tail of the alive order
                        shift_hi  = count_reg - 1'b1;
                        load_en   = 1'b1;
                        load_pos  = count_reg - 1'b1;
                        load_data = best_reg;
                        load_data.deadline = req_reg.now_time + 32'(best_reg.timeout);
                        load_rank = best_rank_reg;
                    end
                    else
                    begin
                        shift_hi   = count_reg;
                        rm_en      = 1'b1;
                        rm_rank    = best_rank_reg;
                        count_next = count_reg - 1'b1;
                    end
                end
            end

            S_CHK_EVAL:
            begin
                if (due)
                begin
                    res_valid_next = 1'b1;
                    res_next = '{kind: K_SEND, peer_id: head.id, last: 1'b0};
                end
                if (expired && due)
                    state_next = S_CHK_RM;
                else
                begin
                    if (expired)
                    begin
                        res_valid_next = 1'b1;
                        res_next = '{kind: K_TIMEOUT, peer_id: head.id, last: 1'b0};
                        shift_hi   = count_reg;
                        rm_en      = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                    else
                    begin
                        // head rotates to the tail
                        shift_hi  = count_reg - 1'b1;
                        load_en   = 1'b1;
                        load_pos  = count_reg - 1'b1;
                        if (due)
                            load_data.next_send = req_reg.now_time + 32'(head.interval);
                    end
                    steps_next = steps_reg - 1'b1;
                    if (steps_reg == CW'(1))
                        state_next = S_CHK_DONE;
                end
            end

            S_CHK_RM:
            begin
                res_valid_next = 1'b1;
                res_next   = '{kind: K_TIMEOUT, peer_id: head.id, last: 1'b0};
                shift_hi   = count_reg;
                rm_en      = 1'b1;
                count_next = count_reg - 1'b1;
                steps_next = steps_reg - 1'b1;
                state_next = (steps_reg == CW'(1)) ? S_CHK_DONE : S_CHK_EVAL;
            end

            S_CHK_DONE:
            begin
                res_valid_next = 1'b1;
                res_next   = '{kind: K_DONE, peer_id: 32'd0, last: 1'b1};
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        steps_reg     <= steps_next;
        idx_reg       <= idx_next;
        found_reg     <= found_next;
        best_pos_reg  <= best_pos_next;
        best_rank_reg <= best_rank_next;
        best_reg      <= best_next;
        req_reg       <= req_next;
        res_reg       <= res_next;
    end

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            cell_ctl_t ctl;
            always_comb
            begin
                ctl.rm_en = rm_en;
                if (load_en && load_pos == CW'(gi))
                    ctl.sel = SEL_LOAD;
                else if (CW'(gi) >= shift_lo && CW'(gi) < shift_hi)
                    ctl.sel = SEL_NEXT;
                else
                    ctl.sel = SEL_HOLD;
            end

            kdt_cell #(.RW(RW)) u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .rm_rank   (rm_rank),
                .nxt_entry (cell_entry[(gi + 1) % ENTRIES]),
                .nxt_rank  (cell_rank[(gi + 1) % ENTRIES]),
                .ld_entry  (load_data),
                .ld_rank   (load_rank),
                .entry     (cell_entry[gi]),
                .rank      (cell_rank[gi])
            );
        end
    endgenerate

    assign busy      = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // table never overfills
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(ENTRIES))
        else $error("entry count above table size");

    // done always closes a check
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind == K_DONE) |-> res.last)
        else $error("check done without last");

    // a check request always gives a response or keeps the unit busy
    a_check_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.opcode == OP_CHECK) |=> (busy || res_valid))
        else $error("check request dropped");

    // a timeout removal in S_CHK_RM never happens on an empty table
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHK_RM) |-> (count_reg != '0))
        else $error("removal from empty table");

endmodule

@@ rtl/core/kdt_cell.sv @@
// One table cell: holds an entry and its insertion rank, takes from its right neighbor.
module kdt_cell
    import kdt_pkg::*;
#(
    parameter int RW = 4
)
(
    input  logic          clk,
    input  cell_ctl_t     ctl,
    input  logic [RW-1:0] rm_rank,
    input  entry_t        nxt_entry,
    input  logic [RW-1:0] nxt_rank,
    input  entry_t        ld_entry,
    input  logic [RW-1:0] ld_rank,
    output entry_t        entry,
    output logic [RW-1:0] rank
);

    entry_t        entry_reg, entry_next;
    logic [RW-1:0] rank_reg, rank_next;
    logic [RW-1:0] rank_src;

    always_comb
    begin
        unique case (ctl.sel)
            SEL_NEXT:
            begin
                entry_next = nxt_entry;
                rank_src   = nxt_rank;
            end
            SEL_LOAD:
            begin
                entry_next = ld_entry;
                rank_src   = ld_rank;
            end
            default:
            begin
                entry_next = entry_reg;
                rank_src   = rank_reg;
            end
        endcase
        // ranks above a removed entry close the gap
        if (ctl.rm_en && (rank_src > rm_rank))
            rank_next = rank_src - 1'b1;
        else
            rank_next = rank_src;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        rank_reg  <= rank_next;
    end

    assign entry = entry_reg;
    assign rank  = rank_reg;

endmodule

@@ dv/keepalive_deadline_table_checker.sv @@
// Checker for the keepalive deadline table: predicts results per request and compares.
`timescale 1ns / 100ps
module keepalive_deadline_table_checker
    import kdt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t req,
    input  logic busy,
    input  logic res_valid,
    input  res_t res,
    output int   fail_count,
    output int   pending,
    output int   result_count
);

    logic        slot_used [ENTRIES];
    logic [31:0] slot_id   [ENTRIES];
    logic [15:0] slot_ivl  [ENTRIES];
    logic [15:0] slot_tmo  [ENTRIES];
    logic [31:0] slot_next [ENTRIES];
    logic [31:0] slot_dl   [ENTRIES];
    int          alive_q[$];
    int          ins_q[$];
    res_t        expected_q[$];

    task automatic report(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    function automatic void drop_slot(int s);
        int k;
        for (k = alive_q.size() - 1; k >= 0; k--)
            if (alive_q[k] == s) alive_q.delete(k);
        for (k = ins_q.size() - 1; k >= 0; k--)
            if (ins_q[k] == s) ins_q.delete(k);
        slot_used[s] = 1'b0;
    endfunction

    function automatic void push_result(logic [2:0] kind, logic [31:0] id);
        res_t r;
        r.kind = kind;
        r.peer_id = id;
        r.last = 1'b0;
        expected_q.push_back(r);
    endfunction

    // Work out the results of one accepted request and update the table copy.
    function automatic void predict_keepalive(req_t q);
        int   first;
        int   s;
        int   hit;
        int   walk[$];
        first = expected_q.size();
        hit = -1;
        case (q.opcode)
            OP_CONNECT, OP_ACCEPT:
            begin
                s = -1;
                for (int k = 0; k < ENTRIES; k++)
                    if (s < 0 && !slot_used[k]) s = k;
                if (s < 0)
                    push_result(K_FULL, 32'd0);
                else
                begin
                    slot_used[s] = 1'b1;
                    slot_id[s] = q.conn_id;
                    slot_tmo[s] = q.recv_timeout;
                    slot_ivl[s] = (q.opcode == OP_CONNECT) ? q.send_interval : 16'd0;
                    slot_next[s] = (q.opcode == OP_CONNECT) ?
                        q.now_time + 32'(q.send_interval) : 32'd0;
                    slot_dl[s] = q.now_time + 32'(q.recv_timeout);
                    alive_q.push_back(s);
                    ins_q.push_back(s);
                    push_result(K_OK, q.conn_id);
                end
            end
            OP_RECV, OP_DISCONNECT:
            begin
                foreach (ins_q[k])
                    if (hit < 0 && slot_id[ins_q[k]] == q.conn_id) hit = ins_q[k];
                if (hit < 0)
                    push_result(K_NOTFOUND, q.conn_id);
                else
                begin
                    if (q.opcode == OP_RECV)
                    begin
                        slot_dl[hit] = q.now_time + 32'(slot_tmo[hit]);
                        for (int k = alive_q.size() - 1; k >= 0; k--)
                            if (alive_q[k] == hit) alive_q.delete(k);
                        alive_q.push_back(hit);
                    end
                    else
                        drop_slot(hit);
                    push_result(K_OK, q.conn_id);
                end
            end
            OP_CHECK:
            begin
                walk = alive_q;
                foreach (walk[k])
                begin
                    s = walk[k];
                    if (slot_next[s] != 0 && q.now_time >= slot_next[s])
                    begin
                        slot_next[s] = q.now_time + 32'(slot_ivl[s]);
                        push_result(K_SEND, slot_id[s]);
                    end
                    if (slot_dl[s] != 0 && q.now_time > slot_dl[s])
                    begin
                        push_result(K_TIMEOUT, slot_id[s]);
                        drop_slot(s);
                    end
                end
                push_result(K_DONE, 32'd0);
            end
            default: ;
        endcase
        if (expected_q.size() > first)
            expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t exp_r;
        if (!rst_n)
        begin
            for (int k = 0; k < ENTRIES; k++) slot_used[k] = 1'b0;
            alive_q.delete();
            ins_q.delete();
            expected_q.delete();
            fail_count = 0;
            result_count = 0;
        end
        else
        begin
            // results first: a request taken this edge cannot have one out yet
            if (res_valid)
            begin
                result_count++;
                if (expected_q.size() == 0)
                    report($sformatf("unexpected result kind %0d id %h", res.kind, res.peer_id));
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (res.kind !== exp_r.kind)
                        report($sformatf("kind %0d, want %0d", res.kind, exp_r.kind));
                    if (res.peer_id !== exp_r.peer_id)
                        report($sformatf("peer_id %h, want %h", res.peer_id, exp_r.peer_id));
                    if (res.last !== exp_r.last)
                        report($sformatf("last %b, want %b", res.last, exp_r.last));
                end
            end
            if (start && !busy)
                predict_keepalive(req);
        end
        pending = expected_q.size();
    end

endmodule

@@ dv/keepalive_deadline_table_unit_tb.sv @@
// Testbench top for the keepalive deadline table: stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module keepalive_deadline_table_unit_tb;
    import kdt_pkg::*;

    localparam int ENTRIES   = ENTRIES_DEF;
    localparam int STALL_MAX = 4000;   // idle cycles with nothing accepted and no result

    logic clk;
    logic rst_n;
    logic start;
    req_t req;
    logic busy;
    logic res_valid;
    res_t res;
    int   fail_count;
    int   pending;
    int   result_count;
    int   idle_pct;        // sender gap chance, percent
    int   stall_cycles;
    int   request_count;
    logic [31:0] clock_now; // model time handed to the block
    logic [31:0] id_pool[8];

    keepalive_deadline_table_unit #(.ENTRIES(ENTRIES)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .req(req),
        .busy(busy), .res_valid(res_valid), .res(res)
    );

    keepalive_deadline_table_checker #(.ENTRIES(ENTRIES)) checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .req(req), .busy(busy),
        .res_valid(res_valid), .res(res), .fail_count(fail_count),
        .pending(pending), .result_count(result_count)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Watchdog: the block accepts a request or emits a result at least every so often.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || res_valid)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_MAX)
        begin
            $display("FAIL keepalive_deadline_table_unit");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Send one request: optional random gap first, then hold start until busy is low.
    // start stays high between back-to-back requests; it drops only for a gap.
    task automatic send_request(input logic [2:0] op, input logic [31:0] id,
                                input logic [15:0] ivl, input logic [15:0] tmo,
                                input logic [31:0] now);
        req_t r;
        r.opcode = op;
        r.conn_id = id;
        r.send_interval = ivl;
        r.recv_timeout = tmo;
        r.now_time = now;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        start <= 1'b1;
        req <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        request_count++;
    endtask

    // Random request, mostly from a small id pool so lookups hit and checks find due entries.
    task automatic random_request();
        logic [2:0]  op;
        logic [31:0] id;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 30)      op = OP_CONNECT;
        else if (pick < 40) op = OP_ACCEPT;
        else if (pick < 60) op = OP_RECV;
        else if (pick < 72) op = OP_DISCONNECT;
        else if (pick < 97) op = OP_CHECK;
        else                op = 3'($urandom_range(7, 5));
        id = ($urandom_range(9) == 0) ? $urandom() : id_pool[$urandom_range(7)];
        clock_now += $urandom_range(6);
        if ($urandom_range(49) == 0) clock_now = $urandom();
        send_request(op, id,
                     ($urandom_range(19) == 0) ? 16'($urandom()) : 16'($urandom_range(8)),
                     ($urandom_range(19) == 0) ? 16'($urandom()) : 16'($urandom_range(12)),
                     clock_now);
    endtask

    // Directed opening: extremes, every operation, full table, unknown ids, empty check.
    task automatic directed_requests();
        send_request(OP_CHECK, 32'd0, 16'd0, 16'd0, 32'd0);               // empty table
        send_request(OP_RECV, 32'hFFFF_FFFF, 16'd0, 16'd0, 32'd5);        // unknown id
        send_request(OP_DISCONNECT, 32'd0, 16'd0, 16'd0, 32'd5);          // unknown id
        send_request(3'd7, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF); // ignored
        send_request(OP_CONNECT, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_0000);
        send_request(OP_ACCEPT, 32'd0, 16'hFFFF, 16'd0, 32'd0);           // never times out
        send_request(OP_CONNECT, 32'd7, 16'd0, 16'd3, 32'd10);            // duplicate below
        send_request(OP_CONNECT, 32'd7, 16'd2, 16'd1, 32'd10);
        send_request(OP_RECV, 32'd7, 16'd0, 16'd0, 32'd11);               // earliest copy
        for (int k = 0; k < 14; k++)                                      // fill and overflow
            send_request(OP_CONNECT, 32'h100 + k, 16'd1, 16'd2, 32'd12);
        send_request(OP_CHECK, 32'd0, 16'd0, 16'd0, 32'd13);              // due and expired
        send_request(OP_DISCONNECT, 32'd7, 16'd0, 16'd0, 32'd13);
        send_request(OP_CHECK, 32'd0, 16'd0, 16'd0, 32'hFFFF_FFFF);       // all but ids 0 and FFFF_FFFF expire
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        idle_pct = 16;
        request_count = 0;
        clock_now = 32'd100;
        foreach (id_pool[k]) id_pool[k] = $urandom();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_requests();
        for (int n = 0; n < 450; n++)
        begin
            // sender gaps in three phases: moderate, heavy, none
            idle_pct = (n < 150) ? 16 : (n < 300) ? 85 : 0;
            random_request();
        end
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Covered %0d requests (directed edges, random mix of all ops) and %0d results.",
                 request_count, result_count);
        if (fail_count == 0)
            $display("PASS keepalive_deadline_table_unit");
        else
            $display("FAIL keepalive_deadline_table_unit");
        $finish;
    end

endmodule

@@ keepalive_deadline_table_unit.f @@
rtl/core/kdt_pkg.sv
rtl/core/kdt_cell.sv
rtl/core/keepalive_deadline_table_unit.sv
dv/keepalive_deadline_table_checker.sv
dv/keepalive_deadline_table_unit_tb.sv
